// ===== rtl/bs3_pkg.sv =====
// ----------------------------------------------------------------------------
// bs3_pkg
// Shared types, widths and helpers for the 3D box sum pooling block.
// ----------------------------------------------------------------------------
`default_nettype none

package bs3_pkg;

	localparam int VOXEL_W   = 8;
	localparam int SUM_W     = 20;
	localparam int IDX_W     = 18;
	localparam int SIZE_W    = 7;
	localparam int BOX_W     = 5;
	localparam int POS_W     = 6;
	localparam int OFF_W     = 4;
	localparam int ADDR_W    = 12;
	localparam int NBXY_W    = 13;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 7;

	localparam int MAX_X   = 64;
	localparam int MAX_Y   = 64;
	localparam int MAX_Z   = 64;
	localparam int MAX_BOX = 16;
	localparam int ACC_DEPTH = MAX_X * MAX_Y;

	localparam int DIV_LANES  = 6;
	localparam int DIV_CNT_W  = $clog2(SIZE_W);
	localparam int OUTQ_DEPTH = 3;

	localparam logic [SIZE_W-1:0] RST_SIZE = SIZE_W'(64);
	localparam logic [BOX_W-1:0]  RST_BOX  = BOX_W'(2);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SIZE_X   = 2'd0,
		CFG_SIZE_Y   = 2'd1,
		CFG_SIZE_Z   = 2'd2,
		CFG_BOX_SIZE = 2'd3
	} cfg_idx_t;

	// geometry derived from the configuration registers
	typedef struct packed {
		logic [SIZE_W-1:0] sx;
		logic [SIZE_W-1:0] sy;
		logic [SIZE_W-1:0] sz;
		logic [BOX_W-1:0]  r;
		logic [SIZE_W-1:0] nbx;
		logic [SIZE_W-1:0] nby;
		logic [SIZE_W-1:0] nbz;
		logic [NBXY_W-1:0] nbxy;
		logic              run;
	} geo_t;

	// counter values recomputed by the setup pass
	typedef struct packed {
		logic              load;
		logic [POS_W-1:0]  bx;
		logic [POS_W-1:0]  by;
		logic [POS_W-1:0]  bz;
		logic [OFF_W-1:0]  ox;
		logic [OFF_W-1:0]  oy;
		logic [OFF_W-1:0]  oz;
		logic [ADDR_W-1:0] row_base;
		logic [IDX_W-1:0]  slab_base;
	} seed_t;

	typedef struct packed {
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic [POS_W-1:0] z;
	} pos_t;

	// per-voxel accumulate request
	typedef struct packed {
		logic [VOXEL_W-1:0] voxel;
		logic [ADDR_W-1:0]  addr;
		logic [IDX_W-1:0]   idx;
		logic               first;
		logic               wr;
		logic               emit;
		logic               last;
	} req_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [IDX_W-1:0] idx;
		logic             last;
	} res_t;

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
		input logic [SIZE_W-1:0] hi);
		logic [SIZE_W-1:0] o;
		if (v == '0) begin
			o = SIZE_W'(1);
		end else if (v > hi) begin
			o = hi;
		end else begin
			o = v;
		end
		return o;
	endfunction

	function automatic logic [BOX_W-1:0] clamp_box(input logic [BOX_W-1:0] v);
		logic [BOX_W-1:0] o;
		if (v == '0) begin
			o = BOX_W'(1);
		end else if (v > BOX_W'(MAX_BOX)) begin
			o = BOX_W'(MAX_BOX);
		end else begin
			o = v;
		end
		return o;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/bs3_setup.sv =====
// ----------------------------------------------------------------------------
// bs3_setup
// Configuration registers and the setup pass: bit-serial division of the
// positions and extents by the box size, then the base products.
// ----------------------------------------------------------------------------
`default_nettype none

module bs3_setup (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [bs3_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bs3_pkg::CFG_W-1:0]     cfg_data,
	input  wire bs3_pkg::pos_t                 pos,
	output bs3_pkg::geo_t                      geo,
	output bs3_pkg::seed_t                     seed
);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_DIV,
		ST_MUL,
		ST_SLAB,
		ST_RUN
	} state_t;

	state_t                            state_q;
	logic [bs3_pkg::SIZE_W-1:0]        size_x_q, size_y_q, size_z_q;
	logic [bs3_pkg::BOX_W-1:0]         box_size_q;
	logic [bs3_pkg::SIZE_W-1:0]        dv_q  [bs3_pkg::DIV_LANES];
	logic [bs3_pkg::OFF_W-1:0]         rem_q [bs3_pkg::DIV_LANES];
	logic [bs3_pkg::SIZE_W-1:0]        dv_d  [bs3_pkg::DIV_LANES];
	logic [bs3_pkg::OFF_W-1:0]         rem_d [bs3_pkg::DIV_LANES];
	logic [bs3_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic [bs3_pkg::NBXY_W-1:0]        nbxy_q;
	logic [bs3_pkg::ADDR_W-1:0]        row_base_q;
	logic [bs3_pkg::SIZE_W-1:0]        sx, sy, sz;
	logic [bs3_pkg::BOX_W-1:0]         r;
	logic [2*bs3_pkg::SIZE_W-1:0]      prod_xy;
	logic [bs3_pkg::NBXY_W-1:0]        prod_row;
	logic [bs3_pkg::IDX_W:0]           prod_slab;

	assign sx = bs3_pkg::clamp_size(size_x_q, bs3_pkg::SIZE_W'(bs3_pkg::MAX_X));
	assign sy = bs3_pkg::clamp_size(size_y_q, bs3_pkg::SIZE_W'(bs3_pkg::MAX_Y));
	assign sz = bs3_pkg::clamp_size(size_z_q, bs3_pkg::SIZE_W'(bs3_pkg::MAX_Z));
	assign r  = bs3_pkg::clamp_box(box_size_q);

	// one restoring step per lane
	always_comb begin
		logic [bs3_pkg::BOX_W-1:0] t;
		logic                      ge;
		for (int i = 0; i < bs3_pkg::DIV_LANES; i++) begin
			t        = {rem_q[i], dv_q[i][bs3_pkg::SIZE_W-1]};
			ge       = (t >= r);
			rem_d[i] = ge ? bs3_pkg::OFF_W'(t - r) : t[bs3_pkg::OFF_W-1:0];
			dv_d[i]  = {dv_q[i][bs3_pkg::SIZE_W-2:0], ge};
		end
	end

	assign prod_xy   = (2*bs3_pkg::SIZE_W)'(dv_q[3]) * (2*bs3_pkg::SIZE_W)'(dv_q[4]);
	assign prod_row  = bs3_pkg::NBXY_W'(dv_q[1][bs3_pkg::POS_W-1:0])
		* bs3_pkg::NBXY_W'(dv_q[3]);
	assign prod_slab = (bs3_pkg::IDX_W+1)'(dv_q[2][bs3_pkg::POS_W-1:0])
		* (bs3_pkg::IDX_W+1)'(nbxy_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			size_x_q   <= bs3_pkg::RST_SIZE;
			size_y_q   <= bs3_pkg::RST_SIZE;
			size_z_q   <= bs3_pkg::RST_SIZE;
			box_size_q <= bs3_pkg::RST_BOX;
			cnt_q      <= '0;
		end else if (cfg_we) begin
			case (bs3_pkg::cfg_idx_t'(cfg_index))
				bs3_pkg::CFG_SIZE_X:   size_x_q   <= cfg_data;
				bs3_pkg::CFG_SIZE_Y:   size_y_q   <= cfg_data;
				bs3_pkg::CFG_SIZE_Z:   size_z_q   <= cfg_data;
				bs3_pkg::CFG_BOX_SIZE: box_size_q <= cfg_data[bs3_pkg::BOX_W-1:0];
				default: ;
			endcase
			state_q <= ST_LOAD;
		end else begin
			case (state_q)
				ST_LOAD: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + bs3_pkg::DIV_CNT_W'(1);
					if (cnt_q == bs3_pkg::DIV_CNT_W'(bs3_pkg::SIZE_W - 1)) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL:  state_q <= ST_SLAB;
				ST_SLAB: state_q <= ST_RUN;
				ST_RUN:  state_q <= ST_RUN;
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			dv_q[0] <= bs3_pkg::SIZE_W'(pos.x);
			dv_q[1] <= bs3_pkg::SIZE_W'(pos.y);
			dv_q[2] <= bs3_pkg::SIZE_W'(pos.z);
			dv_q[3] <= sx;
			dv_q[4] <= sy;
			dv_q[5] <= sz;
			for (int i = 0; i < bs3_pkg::DIV_LANES; i++) begin
				rem_q[i] <= '0;
			end
		end else if (state_q == ST_DIV) begin
			for (int i = 0; i < bs3_pkg::DIV_LANES; i++) begin
				dv_q[i]  <= dv_d[i];
				rem_q[i] <= rem_d[i];
			end
		end
		if (state_q == ST_MUL) begin
			nbxy_q     <= prod_xy[bs3_pkg::NBXY_W-1:0];
			row_base_q <= prod_row[bs3_pkg::ADDR_W-1:0];
		end
	end

	always_comb begin
		geo.sx   = sx;
		geo.sy   = sy;
		geo.sz   = sz;
		geo.r    = r;
		geo.nbx  = dv_q[3];
		geo.nby  = dv_q[4];
		geo.nbz  = dv_q[5];
		geo.nbxy = nbxy_q;
		geo.run  = (state_q == ST_RUN);

		seed.load      = (state_q == ST_SLAB) && !cfg_we;
		seed.bx        = dv_q[0][bs3_pkg::POS_W-1:0];
		seed.by        = dv_q[1][bs3_pkg::POS_W-1:0];
		seed.bz        = dv_q[2][bs3_pkg::POS_W-1:0];
		seed.ox        = rem_q[0];
		seed.oy        = rem_q[1];
		seed.oz        = rem_q[2];
		seed.row_base  = row_base_q;
		seed.slab_base = prod_slab[bs3_pkg::IDX_W-1:0];
	end

endmodule

`default_nettype wire

// ===== rtl/bs3_scan.sv =====
// ----------------------------------------------------------------------------
// bs3_scan
// Scan position, box and offset counters; forms the accumulate request of
// the voxel at the head of the input.
// ----------------------------------------------------------------------------
`default_nettype none

module bs3_scan (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        accept,
	input  wire logic [bs3_pkg::VOXEL_W-1:0] voxel,
	input  wire bs3_pkg::geo_t               geo,
	input  wire bs3_pkg::seed_t              seed,
	output bs3_pkg::pos_t                    pos,
	output bs3_pkg::req_t                    req
);

	logic [bs3_pkg::POS_W-1:0]  pos_x_q, pos_y_q, pos_z_q;
	logic [bs3_pkg::POS_W-1:0]  bx_q, by_q, bz_q;
	logic [bs3_pkg::OFF_W-1:0]  ox_q, oy_q, oz_q;
	logic [bs3_pkg::ADDR_W-1:0] row_base_q;
	logic [bs3_pkg::IDX_W-1:0]  slab_base_q;
	logic [bs3_pkg::OFF_W-1:0]  rm1;
	logic                       end_x, end_y, end_z;
	logic                       in_box;
	logic [bs3_pkg::ADDR_W-1:0] addr;

	assign rm1   = bs3_pkg::OFF_W'(geo.r - bs3_pkg::BOX_W'(1));
	assign end_x = (bs3_pkg::SIZE_W'(pos_x_q) + bs3_pkg::SIZE_W'(1)) >= geo.sx;
	assign end_y = (bs3_pkg::SIZE_W'(pos_y_q) + bs3_pkg::SIZE_W'(1)) >= geo.sy;
	assign end_z = (bs3_pkg::SIZE_W'(pos_z_q) + bs3_pkg::SIZE_W'(1)) >= geo.sz;

	assign in_box = (bs3_pkg::SIZE_W'(bx_q) < geo.nbx)
		&& (bs3_pkg::SIZE_W'(by_q) < geo.nby)
		&& (bs3_pkg::SIZE_W'(bz_q) < geo.nbz);
	assign addr = bs3_pkg::ADDR_W'(bx_q) + row_base_q;

	always_comb begin
		pos.x = pos_x_q;
		pos.y = pos_y_q;
		pos.z = pos_z_q;

		req.voxel = voxel;
		req.addr  = addr;
		req.idx   = bs3_pkg::IDX_W'(addr) + slab_base_q;
		req.first = (ox_q == '0) && (oy_q == '0) && (oz_q == '0);
		req.wr    = in_box;
		req.emit  = in_box && (ox_q == rm1) && (oy_q == rm1) && (oz_q == rm1);
		req.last  = (bs3_pkg::SIZE_W'(bx_q) == geo.nbx - bs3_pkg::SIZE_W'(1))
			&& (bs3_pkg::SIZE_W'(by_q) == geo.nby - bs3_pkg::SIZE_W'(1))
			&& (bs3_pkg::SIZE_W'(bz_q) == geo.nbz - bs3_pkg::SIZE_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			pos_z_q     <= '0;
			bx_q        <= '0;
			by_q        <= '0;
			bz_q        <= '0;
			ox_q        <= '0;
			oy_q        <= '0;
			oz_q        <= '0;
			row_base_q  <= '0;
			slab_base_q <= '0;
		end else if (seed.load) begin
			bx_q        <= seed.bx;
			by_q        <= seed.by;
			bz_q        <= seed.bz;
			ox_q        <= seed.ox;
			oy_q        <= seed.oy;
			oz_q        <= seed.oz;
			row_base_q  <= seed.row_base;
			slab_base_q <= seed.slab_base;
		end else if (accept) begin
			if (!end_x) begin
				pos_x_q <= pos_x_q + bs3_pkg::POS_W'(1);
				if (ox_q == rm1) begin
					ox_q <= '0;
					bx_q <= bx_q + bs3_pkg::POS_W'(1);
				end else begin
					ox_q <= ox_q + bs3_pkg::OFF_W'(1);
				end
			end else begin
				pos_x_q <= '0;
				ox_q    <= '0;
				bx_q    <= '0;
				if (!end_y) begin
					pos_y_q <= pos_y_q + bs3_pkg::POS_W'(1);
					if (oy_q == rm1) begin
						oy_q       <= '0;
						by_q       <= by_q + bs3_pkg::POS_W'(1);
						row_base_q <= row_base_q + bs3_pkg::ADDR_W'(geo.nbx);
					end else begin
						oy_q <= oy_q + bs3_pkg::OFF_W'(1);
					end
				end else begin
					pos_y_q    <= '0;
					oy_q       <= '0;
					by_q       <= '0;
					row_base_q <= '0;
					if (!end_z) begin
						pos_z_q <= pos_z_q + bs3_pkg::POS_W'(1);
						if (oz_q == rm1) begin
							oz_q        <= '0;
							bz_q        <= bz_q + bs3_pkg::POS_W'(1);
							slab_base_q <= slab_base_q + bs3_pkg::IDX_W'(geo.nbxy);
						end else begin
							oz_q <= oz_q + bs3_pkg::OFF_W'(1);
						end
					end else begin
						pos_z_q     <= '0;
						oz_q        <= '0;
						bz_q        <= '0;
						slab_base_q <= '0;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bs3_accum.sv =====
// ----------------------------------------------------------------------------
// bs3_accum
// Box accumulator memory with read-modify-write and write-to-read
// forwarding; produces the finished box sums.
// ----------------------------------------------------------------------------
`default_nettype none

module bs3_accum (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire bs3_pkg::req_t req,
	output logic               push,
	output logic               pend,
	output bs3_pkg::res_t      res
);

	logic [bs3_pkg::SUM_W-1:0] mem [bs3_pkg::ACC_DEPTH];

	logic                      valid_s1;
	bs3_pkg::req_t             req_s1;
	logic [bs3_pkg::SUM_W-1:0] rd_s1;
	logic                      fwd_s1;
	logic [bs3_pkg::SUM_W-1:0] fwd_val_s1;
	logic [bs3_pkg::SUM_W-1:0] base;
	logic [bs3_pkg::SUM_W-1:0] acc;
	logic                      wen;

	assign base = fwd_s1 ? fwd_val_s1 : rd_s1;
	assign acc  = req_s1.first ? bs3_pkg::SUM_W'(req_s1.voxel)
		: base + bs3_pkg::SUM_W'(req_s1.voxel);
	assign wen  = valid_s1 && req_s1.wr;
	assign pend = valid_s1 && req_s1.emit;
	assign push = pend;

	always_comb begin
		res.sum  = acc;
		res.idx  = req_s1.idx;
		res.last = req_s1.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1     <= req;
			fwd_s1     <= wen && (req_s1.addr == req.addr);
			fwd_val_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= mem[req.addr];
		end
		if (wen) begin
			mem[req_s1.addr] <= acc;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bs3_outq.sv =====
// ----------------------------------------------------------------------------
// bs3_outq
// Three-entry result queue between the accumulator and the output port.
// ----------------------------------------------------------------------------
`default_nettype none

module bs3_outq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire bs3_pkg::res_t din,
	input  wire logic          pop,
	output logic [1:0]         count,
	output bs3_pkg::res_t      dout
);

	bs3_pkg::res_t slot_q [bs3_pkg::OUTQ_DEPTH];
	logic [1:0]    wr_ptr_q, rd_ptr_q, count_q;

	function automatic logic [1:0] ptr_inc(input logic [1:0] p);
		return (p == 2'(bs3_pkg::OUTQ_DEPTH - 1)) ? 2'd0 : p + 2'd1;
	endfunction

	assign count = count_q;
	assign dout  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/box_sum_3d_core.sv =====
// ----------------------------------------------------------------------------
// box_sum_3d_core
// Streaming 3D box-counting sum pooling over a voxel volume.
// ----------------------------------------------------------------------------
// Takes one voxel per cycle while voxel_ready is high, in x-fastest scan
// order, and emits one beat per completed box through a three-entry result
// queue. The rate is set by the single accumulator read-modify-write per
// voxel, forwarded between neighbors. After reset and after every
// configuration write, voxel_ready stays low for a setup pass (load,
// bit-serial division by the box size, base products, slab product and
// counter load) that re-derives the box grid and counter offsets.
`default_nettype none

module box_sum_3d_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [bs3_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bs3_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                          voxel_valid,
	output logic                               voxel_ready,
	input  wire logic [bs3_pkg::VOXEL_W-1:0]   voxel,
	output logic                               box_valid,
	input  wire logic                          box_ready,
	output logic [bs3_pkg::SUM_W-1:0]          box_sum,
	output logic [bs3_pkg::IDX_W-1:0]          box_index,
	output logic                               last_box
);

	bs3_pkg::geo_t  geo;
	bs3_pkg::seed_t seed;
	bs3_pkg::pos_t  pos;
	bs3_pkg::req_t  req;
	bs3_pkg::res_t  res;
	bs3_pkg::res_t  dout;
	logic           accept;
	logic           push;
	logic           pend;
	logic           pop;
	logic [1:0]     count;

	assign voxel_ready = geo.run && ((3'(count) + 3'(pend)) < 3'd3);
	assign accept      = voxel_valid && voxel_ready;
	assign box_valid   = (count != 2'd0);
	assign pop         = box_valid && box_ready;
	assign box_sum     = dout.sum;
	assign box_index   = dout.idx;
	assign last_box    = dout.last;

	bs3_setup u_setup (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pos       (pos),
		.geo       (geo),
		.seed      (seed)
	);

	bs3_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.voxel  (voxel),
		.geo    (geo),
		.seed   (seed),
		.pos    (pos),
		.req    (req)
	);

	bs3_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.req    (req),
		.push   (push),
		.pend   (pend),
		.res    (res)
	);

	bs3_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (res),
		.pop    (pop),
		.count  (count),
		.dout   (dout)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(count == 2'd3 && !pop) |-> !push)
		else $error("result queue overflow");

	a_push_follows_beat: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> $past(accept))
		else $error("result without a voxel beat");

	a_cfg_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !voxel_ready)
		else $error("voxel taken during setup pass");

	a_load_only_in_setup: assert property (@(posedge clk) disable iff (!arst_n)
		seed.load |-> !voxel_ready)
		else $error("counter load while taking voxels");

endmodule

`default_nettype wire

// ===== sim/box_sum_3d_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_sum_3d_checker
// Scoreboard for box_sum_3d_core. Follows register writes and voxel beats,
// predicts every completed box (sum, grid index, final-box flag) from its own
// copy of the scan position and slab accumulators, and compares each box beat
// in order against the oldest predicted box.
// ----------------------------------------------------------------------------
module box_sum_3d_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bs3_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bs3_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          voxel_valid,
	input  logic                          voxel_ready,
	input  logic [bs3_pkg::VOXEL_W-1:0]   voxel,
	input  logic                          box_valid,
	input  logic                          box_ready,
	input  logic [bs3_pkg::SUM_W-1:0]     box_sum,
	input  logic [bs3_pkg::IDX_W-1:0]     box_index,
	input  logic                          last_box,
	output int                            mismatches,
	output int                            boxes_due,
	output int                            boxes_checked
);
	import bs3_pkg::*;

	logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
	logic [BOX_W-1:0]  box_q;
	logic [SUM_W-1:0]  slab_sums [ACC_DEPTH];
	int                pos_x, pos_y, pos_z;
	res_t              boxes_owed [$];

	function automatic int bounded(input int v, input int hi);
		if (v == 0)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	task automatic take_voxel(input logic [VOXEL_W-1:0] v);
		int sx, sy, sz, r, nbx, nby, nbz, bx, by, bz, addr;
		logic [SUM_W-1:0] acc;
		res_t beat;
		sx = bounded(size_x_q, MAX_X);
		sy = bounded(size_y_q, MAX_Y);
		sz = bounded(size_z_q, MAX_Z);
		r = bounded(box_q, MAX_BOX);
		nbx = sx / r;
		nby = sy / r;
		nbz = sz / r;
		bx = pos_x / r;
		by = pos_y / r;
		bz = pos_z / r;
		if (bx < nbx && by < nby && bz < nbz) begin
			addr = bx + by * nbx;
			if (pos_x % r == 0 && pos_y % r == 0 && pos_z % r == 0)
				acc = SUM_W'(v);
			else
				acc = slab_sums[addr] + SUM_W'(v);
			slab_sums[addr] = acc;
			if (pos_x % r == r - 1 && pos_y % r == r - 1 && pos_z % r == r - 1) begin
				beat.sum = acc;
				beat.idx = IDX_W'(addr + bz * nbx * nby);
				beat.last = (bx == nbx - 1) && (by == nby - 1) && (bz == nbz - 1);
				boxes_owed.push_back(beat);
			end
		end
		if (pos_x + 1 < sx) begin
			pos_x++;
		end else begin
			pos_x = 0;
			if (pos_y + 1 < sy) begin
				pos_y++;
			end else begin
				pos_y = 0;
				if (pos_z + 1 < sz)
					pos_z++;
				else
					pos_z = 0;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			size_x_q = RST_SIZE;
			size_y_q = RST_SIZE;
			size_z_q = RST_SIZE;
			box_q = RST_BOX;
			pos_x = 0;
			pos_y = 0;
			pos_z = 0;
			boxes_owed.delete();
			mismatches = 0;
			boxes_checked = 0;
		end else begin
			if (box_valid && box_ready) begin
				boxes_checked++;
				if (boxes_owed.size() == 0) begin
					mismatches++;
					$error("box beat with nothing due: box_sum %0d box_index %0d last_box %0b",
						box_sum, box_index, last_box);
				end else begin
					want = boxes_owed.pop_front();
					if (box_sum !== want.sum) begin
						mismatches++;
						$error("box_sum: expected %0d, got %0d", want.sum, box_sum);
					end
					if (box_index !== want.idx) begin
						mismatches++;
						$error("box_index: expected %0d, got %0d", want.idx, box_index);
					end
					if (last_box !== want.last) begin
						mismatches++;
						$error("last_box: expected %0b, got %0b", want.last, last_box);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
				CFG_SIZE_X: size_x_q = cfg_data;
				CFG_SIZE_Y: size_y_q = cfg_data;
				CFG_SIZE_Z: size_z_q = cfg_data;
				CFG_BOX_SIZE: box_q = cfg_data[BOX_W-1:0];
				endcase
			end
			if (voxel_valid && voxel_ready)
				take_voxel(voxel);
		end
		boxes_due = boxes_owed.size();
	end

endmodule

// ===== sim/box_sum_3d_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_sum_3d_core_tb
// Streams voxel volumes of many shapes into box_sum_3d_core: a directed
// opening (reset geometry, clamped and zero sizes, boxes larger than the
// volume, geometry changes partway through a volume), then random volumes with
// random gaps and result backpressure, then one volume of full-scale voxels in
// a single large box. A separate checker predicts and compares every box beat.
// ----------------------------------------------------------------------------
module box_sum_3d_core_tb;
	import bs3_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_VOXELS = 1100;
	localparam int VOLUME_CAP = 300;

	typedef enum int {FILL_RANDOM, FILL_EDGES, FILL_FULL} fill_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 voxel_valid;
	logic                 voxel_ready;
	logic [VOXEL_W-1:0]   voxel;
	logic                 box_valid;
	logic                 box_ready = 1'b0;
	logic [SUM_W-1:0]     box_sum;
	logic [IDX_W-1:0]     box_index;
	logic                 last_box;
	int                   mismatches;
	int                   boxes_due;
	int                   boxes_checked;
	int                   stall_cycles = 0;
	int                   voxels_sent = 0;
	int                   settings_written = 0;
	bit                   quiet = 1'b0;

	box_sum_3d_core dut (.*);

	box_sum_3d_checker scoreboard (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(negedge clk)
		box_ready <= quiet || ($urandom_range(99) >= 32);

	always @(posedge clk) begin
		if (!arst_n || (voxel_valid && voxel_ready) || (box_valid && box_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles == STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic bit take_gap();
		return !quiet && ($urandom_range(99) < 32);
	endfunction

	function automatic logic [VOXEL_W-1:0] pick_voxel(input fill_t fill);
		if (fill == FILL_FULL)
			return '1;
		if (fill == FILL_EDGES && $urandom_range(1))
			return $urandom_range(1) ? '1 : '0;
		return VOXEL_W'($urandom);
	endfunction

	function automatic logic [CFG_W-1:0] raw_size(input int n, input int hi);
		if (n == 1 && $urandom_range(1))
			return '0;
		if (n == hi && $urandom_range(1))
			return CFG_W'($urandom_range(hi + 1, 127));
		return CFG_W'(n);
	endfunction

	function automatic logic [CFG_W-1:0] raw_box(input int n);
		if (n == 1 && $urandom_range(1))
			return '0;
		if (n == MAX_BOX && $urandom_range(1))
			return CFG_W'($urandom_range(MAX_BOX + 1, 31));
		return CFG_W'(n);
	endfunction

	task automatic settle(input int extra);
		voxel_valid <= 1'b0;
		do @(negedge clk); while (boxes_due != 0);
		repeat (extra) @(negedge clk);
	endtask

	task automatic configure(input logic [CFG_W-1:0] sx, sy, sz, box);
		cfg_we <= 1'b1;
		cfg_index <= CFG_SIZE_X;
		cfg_data <= sx;
		@(negedge clk);
		cfg_index <= CFG_SIZE_Y;
		cfg_data <= sy;
		@(negedge clk);
		cfg_index <= CFG_SIZE_Z;
		cfg_data <= sz;
		@(negedge clk);
		cfg_index <= CFG_BOX_SIZE;
		cfg_data <= box;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		settings_written++;
	endtask

	task automatic send_voxel(input logic [VOXEL_W-1:0] v);
		while (take_gap()) begin
			voxel_valid <= 1'b0;
			@(negedge clk);
		end
		voxel_valid <= 1'b1;
		voxel <= v;
		do @(posedge clk); while (!voxel_ready);
		@(negedge clk);
		voxels_sent++;
	endtask

	task automatic send_volume(input int n, input fill_t fill, input bit squeeze);
		for (int i = 0; i < n; i++) begin
			if ((squeeze && i == n / 2) || (!quiet && $urandom_range(199) == 0))
				settle(0);
			send_voxel(pick_voxel(fill));
		end
	endtask

	task automatic choose_shape(output int ex, ey, ez, eb);
		int kind;
		kind = $urandom_range(9);
		do begin
			if (kind == 0) begin
				eb = 1;
				ex = 1;
				ey = 1;
				ez = 1;
				case ($urandom_range(2))
				0: ex = MAX_X;
				1: ey = MAX_Y;
				default: ez = MAX_Z;
				endcase
			end else if (kind == 1) begin
				eb = $urandom_range(5, MAX_BOX);
				ex = $urandom_range(1, 12);
				ey = $urandom_range(1, 12);
				ez = $urandom_range(1, 12);
			end else begin
				eb = $urandom_range(1, 4);
				ex = eb * $urandom_range(1, 3) + $urandom_range(0, eb - 1);
				ey = eb * $urandom_range(1, 3) + $urandom_range(0, eb - 1);
				ez = eb * $urandom_range(1, 3) + $urandom_range(0, eb - 1);
			end
		end while (ex * ey * ez > VOLUME_CAP);
	endtask

	initial begin
		int ex, ey, ez, eb, vol_no, opening;
		fill_t fill;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_SIZE_X;
		cfg_data <= '0;
		voxel_valid <= 1'b0;
		voxel <= '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset geometry, then a unit volume to bring the scan back to the origin
		send_voxel('0);
		send_voxel('1);
		settle(DRAIN_CYCLES);
		configure(0, 0, 0, 31);
		send_voxel('1);
		settle(DRAIN_CYCLES);

		configure(2, 2, 2, 2);
		send_volume(8, FILL_FULL, 1'b0);
		settle(DRAIN_CYCLES);
		configure(0, 1, 0, 0);
		send_voxel('0);
		settle(DRAIN_CYCLES);
		configure(1, 1, 1, 2);
		send_voxel(pick_voxel(FILL_RANDOM));
		settle(DRAIN_CYCLES);

		// widen x after the first voxel plane; the volume ends on the new shape
		configure(2, 2, 2, 2);
		send_volume(4, FILL_RANDOM, 1'b0);
		settle(DRAIN_CYCLES);
		configure(3, 2, 2, 2);
		send_volume(6, FILL_RANDOM, 1'b0);
		settle(DRAIN_CYCLES);

		// shrink x below the current position
		configure(4, 1, 1, 16);
		send_volume(3, FILL_RANDOM, 1'b0);
		settle(DRAIN_CYCLES);
		configure(2, 1, 1, 16);
		send_voxel(pick_voxel(FILL_EDGES));
		settle(DRAIN_CYCLES);

		opening = voxels_sent;
		vol_no = 0;
		while (voxels_sent - opening < RANDOM_VOXELS) begin
			vol_no++;
			quiet <= (vol_no >= 8 && vol_no < 16);
			choose_shape(ex, ey, ez, eb);
			configure(raw_size(ex, MAX_X), raw_size(ey, MAX_Y), raw_size(ez, MAX_Z),
				raw_box(eb));
			if ($urandom_range(9) == 0)
				fill = FILL_FULL;
			else if ($urandom_range(1))
				fill = FILL_EDGES;
			else
				fill = FILL_RANDOM;
			send_volume(ex * ey * ez, fill, vol_no == 3);
			settle(DRAIN_CYCLES);
		end
		quiet <= 1'b0;

		// one large box, every voxel at full scale
		configure(8, 8, 8, 8);
		send_volume(512, FILL_FULL, 1'b0);
		settle(DRAIN_CYCLES);

		$display("covered %0d voxels under %0d register settings, sizes 1..64, box edges 1..16",
			voxels_sent, settings_written);
		$display("compared %0d box beats, %0d field mismatches", boxes_checked, mismatches);
		if (mismatches == 0 && boxes_due == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
